@@ design/wsd_pkg.sv @@
package wsd_pkg;

  localparam int unsigned LenW = 21;
  localparam logic [LenW-1:0] CapReset = 21'd1048576;

  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  // Remaining extended length bytes after the current one
  localparam logic [2:0] ExtLeft16 = 3'd1;
  localparam logic [2:0] ExtLeft64 = 3'd7;
  localparam logic [1:0] KeyLeft   = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_ENDED
  } phase_e;

  typedef enum logic [1:0] {
    RK_BYTE  = 2'd0,
    RK_EMPTY = 2'd1,
    RK_ENDED = 2'd2
  } result_kind_e;

  typedef enum logic {
    END_CLOSE = 1'b0,
    END_CAP   = 1'b1
  } end_reason_e;

  typedef struct packed {
    end_reason_e  end_reason;
    logic         last_of_frame;
    logic         frame_kind;
    logic [7:0]   data_byte;
    result_kind_e result_kind;
  } result_t;

endpackage

@@ design/wsd_parser.sv @@
module wsd_parser #(
  parameter int unsigned POSITION_WIDTH = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [wsd_pkg::LenW-1:0]      cap_i,
  output logic                          res_valid_o,
  output wsd_pkg::result_t              res_o
);

  localparam int unsigned CmpW =
    (POSITION_WIDTH + 1 > wsd_pkg::LenW) ? POSITION_WIDTH + 1 : wsd_pkg::LenW;

  wsd_pkg::phase_e             phase_q, phase_d;
  logic [3:0]                  opcode_q, opcode_d;
  logic                        mask_q, mask_d;
  logic [2:0]                  len_cnt_q, len_cnt_d;
  logic [wsd_pkg::LenW-1:0]    len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic [31:0]                 key_q, key_d;
  logic [1:0]                  key_cnt_q, key_cnt_d;
  logic [POSITION_WIDTH-1:0]   pos_q, pos_d;

  logic                        len_done;
  logic                        key_done;
  logic [POSITION_WIDTH:0]     pos_inc;
  logic [CmpW-1:0]             cmp_pos;
  logic [CmpW-1:0]             cmp_len;
  logic                        last;
  logic [7:0]                  key_byte;
  logic [7:0]                  data;
  logic                        is_text_ping;

  assign is_text_ping = (opcode_q == wsd_pkg::OpText) || (opcode_q == wsd_pkg::OpPing);
  assign pos_inc      = {1'b0, pos_q} + 1'b1;
  assign cmp_pos      = CmpW'(pos_inc);
  assign cmp_len      = CmpW'(len_q);
  assign last         = cmp_pos >= cmp_len;

  // First key byte received sits in the top bits and serves slot 0
  always_comb begin
    unique case (pos_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign data = rx_byte_i ^ (mask_q ? key_byte : 8'h00);

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    len_cnt_d   = len_cnt_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    key_d       = key_q;
    key_cnt_d   = key_cnt_q;
    pos_d       = pos_q;
    len_done    = 1'b0;
    key_done    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{end_reason: wsd_pkg::END_CLOSE, last_of_frame: 1'b0,
                    frame_kind: 1'b0, data_byte: 8'h00,
                    result_kind: wsd_pkg::RK_BYTE};

    unique case (phase_q)
      wsd_pkg::PH_HDR0: begin
        opcode_d = rx_byte_i[3:0];
        phase_d  = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        mask_d = rx_byte_i[7];
        key_d  = '0;
        ovf_d  = 1'b0;
        if (rx_byte_i[6:0] == wsd_pkg::Len7Ext16 ||
            rx_byte_i[6:0] == wsd_pkg::Len7Ext64) begin
          len_cnt_d = (rx_byte_i[6:0] == wsd_pkg::Len7Ext16) ? wsd_pkg::ExtLeft16
                                                             : wsd_pkg::ExtLeft64;
          len_d     = '0;
          phase_d   = wsd_pkg::PH_EXTLEN;
        end else begin
          len_d    = wsd_pkg::LenW'(rx_byte_i[6:0]);
          len_done = 1'b1;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        // Keep the low bits; anything shifted out only matters as overflow
        ovf_d     = ovf_q | (|len_q[wsd_pkg::LenW-1:wsd_pkg::LenW-8]);
        len_d     = {len_q[wsd_pkg::LenW-9:0], rx_byte_i};
        len_cnt_d = len_cnt_q - 1'b1;
        len_done  = (len_cnt_q == '0);
      end
      wsd_pkg::PH_KEY: begin
        key_d     = {key_q[23:0], rx_byte_i};
        key_cnt_d = key_cnt_q - 1'b1;
        key_done  = (key_cnt_q == '0);
      end
      wsd_pkg::PH_PAYLOAD: begin
        pos_d = pos_inc[POSITION_WIDTH-1:0];
        if (last) begin
          phase_d = wsd_pkg::PH_HDR0;
          pos_d   = '0;
        end
        if (last && opcode_q == wsd_pkg::OpClose) begin
          phase_d               = wsd_pkg::PH_ENDED;
          res_valid_o           = 1'b1;
          res_o.result_kind     = wsd_pkg::RK_ENDED;
          res_o.end_reason      = wsd_pkg::END_CLOSE;
        end else if (is_text_ping) begin
          res_valid_o         = 1'b1;
          res_o.result_kind   = wsd_pkg::RK_BYTE;
          res_o.data_byte     = data;
          res_o.frame_kind    = (opcode_q == wsd_pkg::OpPing);
          res_o.last_of_frame = last;
        end
      end
      default: begin
      end
    endcase

    // Length known: cap check, then key phase, or (unmasked) payload start or frame end
    if (len_done) begin
      if (ovf_d || len_d > cap_i) begin
        phase_d           = wsd_pkg::PH_ENDED;
        res_valid_o       = 1'b1;
        res_o.result_kind = wsd_pkg::RK_ENDED;
        res_o.end_reason  = wsd_pkg::END_CAP;
      end else if (mask_d) begin
        key_cnt_d = wsd_pkg::KeyLeft;
        phase_d   = wsd_pkg::PH_KEY;
      end else begin
        key_done = 1'b1;
      end
    end

    if (key_done) begin
      pos_d = '0;
      if (len_d != '0) begin
        phase_d = wsd_pkg::PH_PAYLOAD;
      end else if (opcode_q == wsd_pkg::OpClose) begin
        phase_d           = wsd_pkg::PH_ENDED;
        res_valid_o       = 1'b1;
        res_o.result_kind = wsd_pkg::RK_ENDED;
        res_o.end_reason  = wsd_pkg::END_CLOSE;
      end else begin
        phase_d = wsd_pkg::PH_HDR0;
        if (is_text_ping) begin
          res_valid_o         = 1'b1;
          res_o.result_kind   = wsd_pkg::RK_EMPTY;
          res_o.frame_kind    = (opcode_q == wsd_pkg::OpPing);
          res_o.last_of_frame = 1'b1;
        end
      end
    end

    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsd_pkg::PH_HDR0;
      opcode_q  <= '0;
      mask_q    <= 1'b0;
      len_cnt_q <= '0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      key_q     <= '0;
      key_cnt_q <= '0;
      pos_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_q    <= mask_d;
      len_cnt_q <= len_cnt_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      key_q     <= key_d;
      key_cnt_q <= key_cnt_d;
      pos_q     <= pos_d;
    end
  end

endmodule

@@ design/wsd_out_buf.sv @@
module wsd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             res_valid_i,
  input  wsd_pkg::result_t res_i,
  output logic             advance_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] data_byte
  output logic [3:0]       m_axis_tuser,  // [1:0] result_kind, [2] frame_kind, [3] end_reason
  output logic             m_axis_tlast
);

  logic             valid_q, valid_d;
  wsd_pkg::result_t res_q;

  assign advance_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = res_valid_i;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q.data_byte;
  assign m_axis_tuser  = {res_q.end_reason, res_q.frame_kind, res_q.result_kind};
  assign m_axis_tlast  = res_q.last_of_frame;

endmodule

@@ design/websocket_frame_deframer.sv @@
// WebSocket receive-side frame parser.
// Slave stream: one link byte per beat on s_axis_tdata. Master stream: at most
// one result per byte: a text or ping payload byte (unmasked), an empty-frame
// marker, or a session-ended marker; tlast flags the final byte of a frame.
// Config channel: cfg_data_i writes the payload length cap; write it only while
// the block is idle. Frames longer than the cap end the session.
// Path: a byte accepted on the slave side is held in the input register, and its
// result is written to the result register when that register can take it.
// Throughput: one byte per cycle while the master side takes results; the per-byte
// parse step is a single state update between the input register and the result register.
// Reset: returns to expecting the first header byte, cap = 1048576, both
// stages empty. After a close frame or a cap violation the block swallows
// every byte with no result until the next reset.
// Stall: when the master side stalls, the result register holds its beat; the
// input register still takes one more byte, then s_axis_tready drops until the
// result is taken. A byte that gives no result also waits in the input
// register while a beat is held.
module websocket_frame_deframer #(
  parameter int unsigned POSITION_WIDTH = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [7:0] rx_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // [7:0] data_byte
  output logic [3:0]               m_axis_tuser,  // [1:0] result_kind, [2] frame_kind, [3] end_reason
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [wsd_pkg::LenW-1:0] cfg_data_i
);

  logic                     in_valid_q, in_valid_d;
  logic [7:0]               in_byte_q;
  logic                     advance;
  logic                     step;
  logic [wsd_pkg::LenW-1:0] cap_q;
  logic                     res_valid;
  wsd_pkg::result_t         res;

  // Parse the held byte whenever the result register can take its outcome
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cap_q      <= wsd_pkg::CapReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Hold the byte; payload register needs no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  wsd_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rx_byte_i  (in_byte_q),
    .cap_i      (cap_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsd_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .advance_o    (advance),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
